>>> design/rss_pkg.sv
// shared constants, word types and control codes for the running sample statistics block
// no dependencies; used by every other file of the block
package rss_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int COUNT_BITS    = 24;
    localparam int FRAC_BITS     = 8;

    localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
    localparam int SQR_BITS      = 2 * SAMPLE_BITS;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
    localparam int CHG_BITS      = SAMPLE_BITS + 1;
    localparam int STD_BITS      = SAMPLE_BITS + FRAC_BITS;
    localparam int RAD_BITS      = 2 * STD_BITS;
    localparam int DIV_BITS      = SQ_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);
    localparam int ROOT_CNT_BITS = $clog2(STD_BITS);
    localparam int VAR_BITS      = SQ_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic signed [SAMPLE_BITS-1:0] INT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] INT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first;
        logic                          last;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]         sample_count;
        logic signed [SAMPLE_BITS-1:0] minimum;
        logic signed [SAMPLE_BITS-1:0] maximum;
        logic [SAMPLE_BITS-1:0]        max_change;
        logic [STD_BITS-1:0]           std_dev;
        logic                          overflow;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_START,
        ST_DIV_MEAN,
        ST_DIV_SQ,
        ST_SQRT_START,
        ST_SQRT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic acc;         // accumulate the accepted sample
        logic div_start;   // launch the divider
        logic div_sq;      // divider operand: 0 sum, 1 sum of squares
        logic mean_take;   // latch mean magnitude from divider
        logic var_load;    // form the variance from mean square and mean
        logic sqrt_start;  // launch the root unit
        logic out_load;    // load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
    } dp_status_t;

endpackage

>>> design/rss_div.sv
// iterative restoring divider, one quotient bit per cycle, unsigned operands
// depends on rss_pkg
module rss_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [rss_pkg::DIV_BITS-1:0]    dividend,
    input  logic [rss_pkg::COUNT_BITS-1:0]  divisor,
    output logic [rss_pkg::DIV_BITS-1:0]    quotient,
    output logic                            done
);

    logic [rss_pkg::DIV_BITS-1:0]     dq_reg;
    logic [rss_pkg::COUNT_BITS-1:0]   dvs_reg;
    logic [rss_pkg::COUNT_BITS-1:0]   rem_reg;
    logic [rss_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [rss_pkg::COUNT_BITS:0]     rem_sh;
    logic [rss_pkg::COUNT_BITS:0]     rem_sub;
    logic                             ge;

    assign rem_sh  = {rem_reg, dq_reg[rss_pkg::DIV_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign ge      = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rss_pkg::DIV_CNT_BITS'(rss_pkg::DIV_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[rss_pkg::DIV_BITS-2:0], ge};
            rem_reg <= ge ? rem_sub[rss_pkg::COUNT_BITS-1:0] : rem_sh[rss_pkg::COUNT_BITS-1:0];
        end
    end

    assign quotient = dq_reg;
    assign done     = done_reg;

endmodule

>>> design/rss_sqrt.sv
// iterative integer square root, one root bit per cycle, floored
// depends on rss_pkg
module rss_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rss_pkg::RAD_BITS-1:0]  radicand,
    output logic [rss_pkg::STD_BITS-1:0]  root,
    output logic                          done
);

    localparam int RB = rss_pkg::STD_BITS;

    logic [rss_pkg::RAD_BITS-1:0]      rad_reg;
    logic [RB:0]                       rem_reg;
    logic [RB-1:0]                     root_reg;
    logic [rss_pkg::ROOT_CNT_BITS-1:0] cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;

    logic [RB+1:0] rem_sh;
    logic [RB+1:0] trial;
    logic [RB+1:0] rem_sub;
    logic          ge;

    assign rem_sh  = {rem_reg[RB-1:0], rad_reg[rss_pkg::RAD_BITS-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;
    assign ge      = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rss_pkg::ROOT_CNT_BITS'(RB - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[rss_pkg::RAD_BITS-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[RB:0] : rem_sh[RB:0];
            root_reg <= {root_reg[RB-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

>>> design/rss_dp.sv
// datapath: running accumulators, report arithmetic and result register
// depends on rss_pkg, rss_div and rss_sqrt
module rss_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  rss_pkg::ctrl_cmd_t  cmd,
    input  rss_pkg::in_word_t   s_word,
    output rss_pkg::dp_status_t sts,
    output rss_pkg::out_word_t  m_word
);

    localparam int SB = rss_pkg::SAMPLE_BITS;

    logic [rss_pkg::COUNT_BITS-1:0]   count_reg, count_next;
    logic signed [rss_pkg::SUM_BITS-1:0] sum_reg, sum_next;
    logic [rss_pkg::SQ_BITS-1:0]      sum_sq_reg, sum_sq_next;
    logic signed [SB-1:0]             max_reg, max_next;
    logic signed [SB-1:0]             min_reg, min_next;
    logic signed [SB-1:0]             prev_reg;
    logic [rss_pkg::CHG_BITS-1:0]     change_reg, change_next;
    logic                             sat_reg, sat_next;
    logic [rss_pkg::SQR_BITS-1:0]     sq_reg;
    logic                             pend_reg, pend_next;

    logic [SB-1:0]                    e1_reg;
    logic [rss_pkg::SQR_BITS-1:0]     e1sq_reg;
    logic [rss_pkg::SQR_BITS-1:0]     var_reg;
    rss_pkg::out_word_t               out_reg;

    logic signed [SB-1:0]             x;
    logic [rss_pkg::COUNT_BITS-1:0]   base_count;
    logic signed [rss_pkg::SUM_BITS-1:0] base_sum;
    logic signed [SB-1:0]             base_max, base_min;
    logic [rss_pkg::CHG_BITS-1:0]     base_change;
    logic                             base_sat;
    logic                             sat_now;
    logic                             had_prior;
    logic signed [rss_pkg::CHG_BITS-1:0] diff;
    logic [rss_pkg::CHG_BITS-1:0]     abs_diff;
    logic signed [rss_pkg::SQR_BITS-1:0] sq_now;

    logic [rss_pkg::SUM_BITS-1:0]     sum_mag;
    logic [rss_pkg::DIV_BITS-1:0]     div_dividend;
    logic [rss_pkg::DIV_BITS-1:0]     div_q;
    logic [rss_pkg::VAR_BITS-1:0]     var_full;
    logic [rss_pkg::STD_BITS-1:0]     root;

    // accumulator update for one accepted sample
    always_comb begin
        x           = s_word.sample;
        base_count  = s_word.first ? '0 : count_reg;
        base_sum    = s_word.first ? '0 : sum_reg;
        base_max    = s_word.first ? rss_pkg::INT_MIN : max_reg;
        base_min    = s_word.first ? rss_pkg::INT_MAX : min_reg;
        base_change = s_word.first ? '0 : change_reg;
        base_sat    = s_word.first ? 1'b0 : sat_reg;
        sat_now     = (base_count == rss_pkg::COUNT_MAX);
        had_prior   = (base_count != '0);

        count_next  = sat_now ? base_count : base_count + 1'b1;
        sum_next    = sat_now ? base_sum
                              : base_sum + rss_pkg::SUM_BITS'(x);
        sat_next    = base_sat | sat_now;
        max_next    = (x > base_max) ? x : base_max;
        min_next    = (x < base_min) ? x : base_min;

        diff        = $signed({x[SB-1], x}) - $signed({prev_reg[SB-1], prev_reg});
        abs_diff    = diff[rss_pkg::CHG_BITS-1] ? rss_pkg::CHG_BITS'(-diff)
                                                : rss_pkg::CHG_BITS'(diff);
        change_next = (had_prior && (abs_diff > base_change)) ? abs_diff : base_change;

        sq_now      = rss_pkg::SQR_BITS'(x) * rss_pkg::SQR_BITS'(x);
        pend_next   = cmd.acc & ~sat_now;

        // the square is registered in sq_reg before it is added to the sum of squares
        if (cmd.acc && s_word.first) begin
            sum_sq_next = '0;
        end else if (pend_reg) begin
            sum_sq_next = sum_sq_reg + rss_pkg::SQ_BITS'(sq_reg);
        end else begin
            sum_sq_next = sum_sq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            sum_reg    <= '0;
            sum_sq_reg <= '0;
            max_reg    <= rss_pkg::INT_MIN;
            min_reg    <= rss_pkg::INT_MAX;
            prev_reg   <= '0;
            change_reg <= '0;
            sat_reg    <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            sum_sq_reg <= sum_sq_next;
            pend_reg   <= pend_next;
            if (cmd.acc) begin
                count_reg  <= count_next;
                sum_reg    <= sum_next;
                max_reg    <= max_next;
                min_reg    <= min_next;
                prev_reg   <= x;
                change_reg <= change_next;
                sat_reg    <= sat_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sq_reg <= rss_pkg::SQR_BITS'(sq_now);
    end

    // report arithmetic
    assign sum_mag      = sum_reg[rss_pkg::SUM_BITS-1] ? rss_pkg::SUM_BITS'(-sum_reg)
                                                       : rss_pkg::SUM_BITS'(sum_reg);
    assign div_dividend = cmd.div_sq ? sum_sq_reg : rss_pkg::DIV_BITS'(sum_mag);

    rss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .quotient (div_q),
        .done     (sts.div_done)
    );

    // the mean enters only squared, so its magnitude is enough
    assign var_full = {1'b0, div_q} - rss_pkg::VAR_BITS'(e1sq_reg);

    always_ff @(posedge aclk) begin
        e1sq_reg <= rss_pkg::SQR_BITS'(e1_reg) * rss_pkg::SQR_BITS'(e1_reg);
        if (cmd.mean_take) begin
            e1_reg <= div_q[SB-1:0];
        end
        if (cmd.var_load) begin
            var_reg <= var_full[rss_pkg::VAR_BITS-1] ? '0 : var_full[rss_pkg::SQR_BITS-1:0];
        end
    end

    rss_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (rss_pkg::RAD_BITS'(var_reg) << (2 * rss_pkg::FRAC_BITS)),
        .root     (root),
        .done     (sts.sqrt_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.sample_count <= count_reg;
            out_reg.minimum      <= min_reg;
            out_reg.maximum      <= max_reg;
            out_reg.max_change   <= change_reg[SB-1:0];
            out_reg.std_dev      <= root;
            out_reg.overflow     <= sat_reg;
        end
    end

    assign m_word = out_reg;

endmodule

>>> design/rss_ctrl.sv
// controller: sequences accumulation, the two divisions, the root and the result hand-off
// depends on rss_pkg
module rss_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  rss_pkg::dp_status_t sts,
    output rss_pkg::ctrl_cmd_t  cmd
);

    rss_pkg::ctrl_state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    assign out_free = ~m_valid_reg | m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rss_pkg::ST_IDLE: begin
                if (s_valid && s_last) begin
                    state_next = rss_pkg::ST_MEAN_START;
                end
            end
            rss_pkg::ST_MEAN_START: state_next = rss_pkg::ST_DIV_MEAN;
            rss_pkg::ST_DIV_MEAN: begin
                if (sts.div_done) begin
                    state_next = rss_pkg::ST_DIV_SQ;
                end
            end
            rss_pkg::ST_DIV_SQ: begin
                if (sts.div_done) begin
                    state_next = rss_pkg::ST_SQRT_START;
                end
            end
            rss_pkg::ST_SQRT_START: state_next = rss_pkg::ST_SQRT;
            rss_pkg::ST_SQRT: begin
                if (sts.sqrt_done) begin
                    state_next = rss_pkg::ST_DONE;
                end
            end
            rss_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rss_pkg::ST_IDLE;
                end
            end
            default: state_next = rss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            rss_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.acc = s_valid;
            end
            rss_pkg::ST_MEAN_START: begin
                cmd.div_start = 1'b1;
            end
            rss_pkg::ST_DIV_MEAN: begin
                cmd.mean_take = sts.div_done;
                cmd.div_start = sts.div_done;
                cmd.div_sq    = 1'b1;
            end
            rss_pkg::ST_DIV_SQ: begin
                cmd.div_sq   = 1'b1;
                cmd.var_load = sts.div_done;
            end
            rss_pkg::ST_SQRT_START: begin
                cmd.sqrt_start = 1'b1;
            end
            rss_pkg::ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rss_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_last_starts_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> state_reg == rss_pkg::ST_MEAN_START)
        else $error("report sequence did not start after a last word");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == rss_pkg::ST_DIV_MEAN
                          || state_reg == rss_pkg::ST_DIV_SQ))
        else $error("divider finished outside a division state");

    a_sqrt_done_in_sqrt: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.sqrt_done |-> state_reg == rss_pkg::ST_SQRT)
        else $error("root unit finished outside the root state");

    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_valid_reg && state_reg == rss_pkg::ST_IDLE))
        else $error("loaded result not presented");
`endif

endmodule

>>> design/running_sample_statistics.sv
// top level of the running sample statistics block
// depends on rss_pkg, rss_ctrl and rss_dp (which holds rss_div and rss_sqrt)
//
// usage:
//   s_ channel: one word per sample (sample, first, last), valid/ready handshake
//   m_ channel: one report word per sample that had last set, valid/ready handshake
//   a word with first set clears count, sums, min, max and
//   largest change before its sample is taken; the largest change reads 0
//   until two samples have been taken; the count saturates and sets overflow
//   throughput: plain samples are taken one per cycle while no report is being computed
//   report: a word with last set is accumulated in its accept cycle, then the
//   block computes mean and mean square with one shared restoring divider
//   (one bit a cycle), then a floored root (one bit a cycle); s_ready stays
//   low until the report sits in the output register
//   stall: the output register holds the report until m_ready; meanwhile
//   plain samples keep accumulating, and a further last word computes but
//   waits for the register to free up before s_ready returns
//   reset: aresetn synchronous active low, clears all statistics and drops
//   m_valid; s_ready is high from the first cycle after reset
module running_sample_statistics (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rss_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output rss_pkg::out_word_t m_word
);

    rss_pkg::ctrl_cmd_t  cmd;
    rss_pkg::dp_status_t sts;

    // sequencing: handshakes and the report sequence
    rss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_word.last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // accumulators, divider, root unit and result register
    rss_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_word  (s_word),
        .sts     (sts),
        .m_word  (m_word)
    );

endmodule
